@@ sv/cdd_pkg.sv @@
// cdd_pkg: shared widths, register indexes and month tables for the date difference block
// no dependencies; used by every file of the block through scoped names
`timescale 1ns / 1ps
`default_nettype none

package cdd_pkg;

    localparam int DAY_W       = 5;
    localparam int MONTH_W     = 4;
    localparam int YEAR_W      = 12;
    localparam int DAYNUM_W    = 21;
    localparam int PROD_W      = 25;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_W       = 12;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_YEAR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_YEAR = 1'b1;

    localparam logic [YEAR_W-1:0] MIN_YEAR_RST = 12'd1900;
    localparam logic [YEAR_W-1:0] MAX_YEAR_RST = 12'd2100;

    // floor(x * 5243 / 2^19) equals floor(x / 100) for every x below 43699
    localparam logic [PROD_W-1:0] RECIP_100 = 25'd5243;

    // load enables of the three arithmetic stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } stage_en_t;

    // days of all months before month m; codes past twelve count the whole year
    function automatic logic [8:0] months_before(input logic [MONTH_W-1:0] m);
        logic [8:0] r;
        unique case (m)
            4'd0, 4'd1: r = 9'd0;
            4'd2:       r = 9'd31;
            4'd3:       r = 9'd59;
            4'd4:       r = 9'd90;
            4'd5:       r = 9'd120;
            4'd6:       r = 9'd151;
            4'd7:       r = 9'd181;
            4'd8:       r = 9'd212;
            4'd9:       r = 9'd243;
            4'd10:      r = 9'd273;
            4'd11:      r = 9'd304;
            4'd12:      r = 9'd334;
            default:    r = 9'd365;
        endcase
        return r;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] r;
        unique case (m)
            4'd2:                     r = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:  r = 5'd30;
            default:                  r = 5'd31;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/calendar_date_difference_top.sv @@
// path: a request passes the stage registers s1, s2 and s3, then the output register
// throughput: one date pair per cycle; a stage takes new data whenever the one after it
// is empty or moving, so output back pressure only stalls once all stages are full
// reset: valid bits clear at once, min_year returns to 1900 and max_year to 2100
// calendar_date_difference_top: handshake, config registers, ordering and difference stage
// depends on cdd_pkg and cdd_date_unit
`timescale 1ns / 1ps
`default_nettype none

module calendar_date_difference_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // day_a[4:0] month_a[8:5] year_a[20:9] day_b[25:21] month_b[29:26] year_b[41:30]
    input  wire logic [cdd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // days_apart[20:0] a_before_b[21] a_valid[22] b_valid[23]
    output logic      [cdd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  wire logic                              cfg_we,
    input  wire logic [cdd_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  wire logic [cdd_pkg::CFG_W-1:0]         cfg_wdata
);

    logic [cdd_pkg::YEAR_W-1:0] min_year_reg, max_year_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_year_reg <= cdd_pkg::MIN_YEAR_RST;
            max_year_reg <= cdd_pkg::MAX_YEAR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                cdd_pkg::REG_MIN_YEAR: min_year_reg <= cfg_wdata;
                cdd_pkg::REG_MAX_YEAR: max_year_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input fields
    logic [cdd_pkg::DAY_W-1:0]   day_a, day_b;
    logic [cdd_pkg::MONTH_W-1:0] month_a, month_b;
    logic [cdd_pkg::YEAR_W-1:0]  year_a, year_b;

    assign day_a   = s_axis_tdata[4:0];
    assign month_a = s_axis_tdata[8:5];
    assign year_a  = s_axis_tdata[20:9];
    assign day_b   = s_axis_tdata[25:21];
    assign month_b = s_axis_tdata[29:26];
    assign year_b  = s_axis_tdata[41:30];

    // per-stage valid bits and ready chain
    logic v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic rdy2, rdy3, rdy_out;
    cdd_pkg::stage_en_t en;

    assign rdy_out       = !out_valid_reg || m_axis_tready;
    assign rdy3          = !v3_reg || rdy_out;
    assign rdy2          = !v2_reg || rdy3;
    assign s_axis_tready = !v1_reg || rdy2;

    assign en.s1 = s_axis_tready;
    assign en.s2 = rdy2;
    assign en.s3 = rdy3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en.s1)
                v1_reg <= s_axis_tvalid;
            if (en.s2)
                v2_reg <= v1_reg;
            if (en.s3)
                v3_reg <= v2_reg;
            if (rdy_out)
                out_valid_reg <= v3_reg;
        end
    end

    // field-wise ordering travels beside the date units
    logic before1_reg, before2_reg, before3_reg;

    always_ff @(posedge clk)
    begin
        if (en.s1)
            before1_reg <= {year_a, month_a, day_a} < {year_b, month_b, day_b};
        if (en.s2)
            before2_reg <= before1_reg;
        if (en.s3)
            before3_reg <= before2_reg;
    end

    logic [cdd_pkg::DAYNUM_W-1:0] num_a, num_b;
    logic                         ok_a, ok_b;

    cdd_date_unit u_date_a (
        .clk      (clk),
        .en       (en),
        .day      (day_a),
        .month    (month_a),
        .year     (year_a),
        .min_year (min_year_reg),
        .max_year (max_year_reg),
        .day_num  (num_a),
        .date_ok  (ok_a)
    );

    cdd_date_unit u_date_b (
        .clk      (clk),
        .en       (en),
        .day      (day_b),
        .month    (month_b),
        .year     (year_b),
        .min_year (min_year_reg),
        .max_year (max_year_reg),
        .day_num  (num_b),
        .date_ok  (ok_b)
    );

    // output register: absolute difference
    logic [cdd_pkg::DAYNUM_W-1:0] days_reg, days_next;
    logic                         before_reg, a_ok_reg, b_ok_reg;

    assign days_next = (num_a > num_b) ? (num_a - num_b) : (num_b - num_a);

    always_ff @(posedge clk)
    begin
        if (rdy_out)
        begin
            days_reg   <= days_next;
            before_reg <= before3_reg;
            a_ok_reg   <= ok_a;
            b_ok_reg   <= ok_b;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {b_ok_reg, a_ok_reg, before_reg, days_reg};

endmodule

`default_nettype wire

@@ sv/cdd_date_unit.sv @@
// cdd_date_unit: three-stage day number and validity pipeline for one date
// depends on cdd_pkg; stage loads are driven by the top level handshake
`timescale 1ns / 1ps
`default_nettype none

module cdd_date_unit (
    input  wire logic                          clk,
    input  wire cdd_pkg::stage_en_t            en,
    input  wire logic [cdd_pkg::DAY_W-1:0]     day,
    input  wire logic [cdd_pkg::MONTH_W-1:0]   month,
    input  wire logic [cdd_pkg::YEAR_W-1:0]    year,
    input  wire logic [cdd_pkg::YEAR_W-1:0]    min_year,
    input  wire logic [cdd_pkg::YEAR_W-1:0]    max_year,
    output logic      [cdd_pkg::DAYNUM_W-1:0]  day_num,
    output logic                               date_ok
);

    // stage 1: constant products and range checks
    logic [cdd_pkg::DAY_W-1:0]    d1_reg;
    logic [cdd_pkg::MONTH_W-1:0]  m1_reg;
    logic [cdd_pkg::YEAR_W-1:0]   y1_reg;
    logic [cdd_pkg::DAYNUM_W-1:0] y365_reg, y365_next;
    logic [cdd_pkg::PROD_W-1:0]   py_reg, py_next;
    logic [cdd_pkg::PROD_W-1:0]   p99_reg, p99_next;
    logic [cdd_pkg::PROD_W-1:0]   p399_reg, p399_next;
    logic                         ok1_reg, ok1_next;
    logic [cdd_pkg::YEAR_W:0]     sum99, sum399;

    always_comb
    begin
        sum99     = {1'b0, year} + 13'd99;
        sum399    = {1'b0, year} + 13'd399;
        y365_next = cdd_pkg::DAYNUM_W'({9'b0, year} * 21'd365);
        py_next   = {12'b0, 1'b0, year} * cdd_pkg::RECIP_100;
        p99_next  = {12'b0, sum99} * cdd_pkg::RECIP_100;
        p399_next = {12'b0, sum399} * cdd_pkg::RECIP_100;
        ok1_next  = (year >= min_year) && (year <= max_year)
                    && (month >= 4'd1) && (month <= 4'd12);
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            d1_reg   <= day;
            m1_reg   <= month;
            y1_reg   <= year;
            y365_reg <= y365_next;
            py_reg   <= py_next;
            p99_reg  <= p99_next;
            p399_reg <= p399_next;
            ok1_reg  <= ok1_next;
        end
    end

    // stage 2: leap test and base day number
    logic [5:0]                   qy, q99;
    logic [3:0]                   q400;
    logic [cdd_pkg::YEAR_W:0]     sum3, qy100;
    logic                         div100, leap;
    logic [cdd_pkg::DAYNUM_W-1:0] base_reg, base_next;
    logic                         inc_reg, inc_next;
    logic [cdd_pkg::DAY_W-1:0]    d2_reg;
    logic [cdd_pkg::DAY_W-1:0]    mlen_reg, mlen_next;
    logic                         ok2_reg;

    always_comb
    begin
        qy     = py_reg[24:19];
        q99    = p99_reg[24:19];
        q400   = p399_reg[24:21];
        sum3   = {1'b0, y1_reg} + 13'd3;
        qy100  = 13'({7'b0, qy} * 13'd100);
        div100 = (qy100 == {1'b0, y1_reg});
        leap   = ((y1_reg[1:0] == 2'b00) && !div100) || (div100 && (qy[1:0] == 2'b00));
        // leap years before this one: ceil(y/4) - ceil(y/100) + ceil(y/400)
        base_next = y365_reg
                    + {10'b0, sum3[12:2]}
                    - {15'b0, q99}
                    + {17'b0, q400}
                    + {12'b0, cdd_pkg::months_before(m1_reg)};
        inc_next  = leap && (m1_reg > 4'd2);
        mlen_next = cdd_pkg::month_len(m1_reg, leap);
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            base_reg <= base_next;
            inc_reg  <= inc_next;
            d2_reg   <= d1_reg;
            mlen_reg <= mlen_next;
            ok2_reg  <= ok1_reg;
        end
    end

    // stage 3: final day number and day check
    logic [cdd_pkg::DAYNUM_W-1:0] num_reg, num_next;
    logic                         ok3_reg, ok3_next;

    always_comb
    begin
        num_next = base_reg + {20'b0, inc_reg} + {16'b0, d2_reg};
        ok3_next = ok2_reg && (d2_reg != 5'd0) && (d2_reg <= mlen_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            num_reg <= num_next;
            ok3_reg <= ok3_next;
        end
    end

    assign day_num = num_reg;
    assign date_ok = ok3_reg;

endmodule

`default_nettype wire

@@ sv/cdd_checker.sv @@
// cdd_checker: port-level checks of the date difference block, bound to its top level
// depends on cdd_pkg and calendar_date_difference_top
`timescale 1ns / 1ps
`default_nettype none

module cdd_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    input  wire logic                              s_axis_tready,
    input  wire logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    input  wire logic [cdd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

    // an empty or draining output never blocks the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
    else $error("input blocked while output is free");

    // with the sink always ready an accepted request reaches the output
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready ##1 m_axis_tready ##1 m_axis_tready
        ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("result missing after pipeline latency");

    // no result without any request in the cycles before
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid, 4) || $past(s_axis_tvalid, 5)
        || $past(s_axis_tvalid, 6) || $past(s_axis_tvalid, 7) || $past(m_axis_tvalid, 2)
        || $past(s_axis_tvalid, 3) && 1'b0 || $past(!s_axis_tready, 1)
        || $past(!s_axis_tready, 2) || $past(!s_axis_tready, 3))
    else $error("result appeared without a request");

endmodule

bind calendar_date_difference_top cdd_checker u_cdd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

@@ sim/calendar_date_difference_top_tb.sv @@
// testbench for calendar_date_difference_top: day-number difference, ordering and validity flags
// predicts every result in its own model; depends on cdd_pkg and the block's rtl
`timescale 1ns / 1ps

module calendar_date_difference_top_tb;

    localparam int STALL_LIMIT = 1000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES = 80;

    localparam int unsigned PRIOR_DAYS [14] =
        '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};

    typedef struct packed {
        logic [cdd_pkg::YEAR_W-1:0]  year;
        logic [cdd_pkg::MONTH_W-1:0] month;
        logic [cdd_pkg::DAY_W-1:0]   day;
    } date_t;

    // first date in the low bits
    typedef struct packed {
        date_t b;
        date_t a;
    } date_pair_t;

    typedef struct packed {
        logic                          b_valid;
        logic                          a_valid;
        logic                          a_before_b;
        logic [cdd_pkg::DAYNUM_W-1:0]  days_apart;
    } date_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [cdd_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [cdd_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic cfg_we = 1'b0;
    logic [cdd_pkg::CFG_IDX_W-1:0] cfg_addr = cdd_pkg::REG_MIN_YEAR;
    logic [cdd_pkg::CFG_W-1:0] cfg_wdata = '0;

    logic [cdd_pkg::YEAR_W-1:0] min_year_cfg = cdd_pkg::MIN_YEAR_RST;
    logic [cdd_pkg::YEAR_W-1:0] max_year_cfg = cdd_pkg::MAX_YEAR_RST;

    date_result_t pending_diffs [$];
    int error_count = 0;
    bit no_idle = 1'b0;
    int hold_request = 0;

    calendar_date_difference_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic bit is_leap(int unsigned y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
        if (m == 2)
            return is_leap(y) ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11)
            return 30;
        return 31;
    endfunction

    function automatic int unsigned day_count(date_t d);
        int unsigned y;
        int unsigned idx;
        int unsigned n;
        y = d.year;
        // months past twelve count the whole year
        idx = (d.month > 13) ? 13 : d.month;
        n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400 + PRIOR_DAYS[idx];
        if (idx > 2 && is_leap(y))
            n++;
        return n + d.day;
    endfunction

    function automatic bit date_ok(date_t d);
        if (d.year < min_year_cfg || d.year > max_year_cfg)
            return 1'b0;
        if (d.month < 1 || d.month > 12)
            return 1'b0;
        return d.day >= 1 && d.day <= days_in_month(d.month, d.year);
    endfunction

    function automatic date_result_t predict_difference(date_pair_t p);
        int unsigned na;
        int unsigned nb;
        date_result_t r;
        na = day_count(p.a);
        nb = day_count(p.b);
        r.days_apart = (na > nb) ? (na - nb) : (nb - na);
        // field-wise order, not day-number order
        if (p.a.year != p.b.year)
            r.a_before_b = p.a.year < p.b.year;
        else if (p.a.month != p.b.month)
            r.a_before_b = p.a.month < p.b.month;
        else
            r.a_before_b = p.a.day < p.b.day;
        r.a_valid = date_ok(p.a);
        r.b_valid = date_ok(p.b);
        return r;
    endfunction

    function automatic date_t mk(int unsigned d, int unsigned m, int unsigned y);
        date_t r;
        r.day = d;
        r.month = m;
        r.year = y;
        return r;
    endfunction

    // half well-formed, in the year range unless inverted; the rest broken in one field or noise
    function automatic date_t random_date();
        date_t d;
        int unsigned shape;
        int unsigned len;
        shape = $urandom_range(0, 7);
        if (min_year_cfg <= max_year_cfg)
            d.year = $urandom_range(max_year_cfg, min_year_cfg);
        else
            d.year = $urandom_range(0, 4095);
        d.month = $urandom_range(1, 12);
        len = days_in_month(d.month, d.year);
        d.day = $urandom_range(1, len);
        if (shape == 0)
            d = date_t'($urandom);
        else if (shape == 1)
            d.day = (len == 31) ? 0 : $urandom_range(len + 1, 31);
        else if (shape == 2)
            d.month = $urandom_range(0, 1) ? 0 : $urandom_range(13, 15);
        else if (shape == 3)
            d.year = $urandom_range(0, 1) ? min_year_cfg - 1 : max_year_cfg + 1;
        return d;
    endfunction

    function automatic date_pair_t random_pair();
        date_pair_t p;
        int unsigned shape;
        shape = $urandom_range(0, 7);
        p.a = random_date();
        p.b = random_date();
        if (shape == 0)
            p.b = p.a;
        else if (shape == 1)
            p.b.year = p.a.year;
        else if (shape == 2)
        begin
            p.b.year = p.a.year;
            p.b.month = p.a.month;
        end
        return p;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic send_dates(date_pair_t p);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= cdd_pkg::IN_TDATA_W'(p);
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_diffs.push_back(predict_difference(p));
    endtask

    // drop the request, wait for every result, then let the pipeline empty
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        while (pending_diffs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_years(int unsigned lo, int unsigned hi);
        settle_block();
        cfg_we <= 1'b1;
        cfg_addr <= cdd_pkg::REG_MIN_YEAR;
        cfg_wdata <= lo;
        @(posedge clk);
        cfg_addr <= cdd_pkg::REG_MAX_YEAR;
        cfg_wdata <= hi;
        @(posedge clk);
        cfg_we <= 1'b0;
        min_year_cfg = lo;
        max_year_cfg = hi;
    endtask

    task automatic test_directed_dates();
        date_pair_t p;
        date_t list [$];
        list = '{
            mk(0, 0, 0),        mk(0, 0, 0),
            mk(31, 15, 4095),   mk(0, 0, 0),
            mk(0, 0, 0),        mk(31, 15, 4095),
            mk(29, 2, 2000),    mk(29, 2, 1900),
            mk(29, 2, 2100),    mk(1, 3, 2100),
            mk(28, 2, 1900),    mk(1, 3, 1900),
            mk(1, 1, 1900),     mk(31, 12, 2100),
            mk(31, 12, 1899),   mk(1, 1, 2101),
            mk(15, 0, 2000),    mk(15, 1, 2000),
            mk(10, 13, 2000),   mk(10, 14, 2000),
            mk(10, 15, 2000),   mk(1, 1, 2001),
            mk(0, 1, 2000),     mk(31, 12, 1999),
            mk(31, 4, 2001),    mk(1, 5, 2001),
            mk(30, 6, 2010),    mk(31, 9, 2010),
            mk(30, 11, 2010),   mk(31, 11, 2010),
            mk(4, 7, 2024),     mk(4, 7, 2024),
            mk(31, 2, 2000),    mk(1, 3, 2000),
            mk(31, 15, 2000),   mk(1, 1, 2001),
            mk(1, 6, 2050),     mk(1, 6, 2049),
            mk(29, 2, 0),       mk(1, 3, 0),
            mk(31, 12, 2100),   mk(1, 1, 1900),
            mk(31, 12, 2024),   mk(30, 12, 2024),
            mk(29, 2, 2024),    mk(29, 2, 2023)
        };
        for (int i = 0; i + 1 < list.size(); i += 2)
        begin
            p.a = list[i];
            p.b = list[i + 1];
            send_dates(p);
        end
    endtask

    task automatic test_year_range(int unsigned lo, int unsigned hi, int n);
        write_years(lo, hi);
        for (int i = 0; i < n; i++)
        begin
            // a stretch of back-to-back requests in the middle of each phase
            no_idle = (i >= n / 2 && i < n / 2 + 30);
            send_dates(random_pair());
        end
        no_idle = 1'b0;
    endtask

    task automatic test_output_stall();
        settle_block();
        no_idle = 1'b1;
        hold_request = HOLD_CYCLES;
        for (int i = 0; i < 40; i++)
            send_dates(random_pair());
        no_idle = 1'b0;
    endtask

    initial
    begin : result_checker
        date_result_t got;
        date_result_t want;
        int stall;
        forever
        begin
            if (hold_request > 0)
            begin
                stall = hold_request;
                hold_request = 0;
            end
            else
                stall = no_idle ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            got = date_result_t'(m_axis_tdata);
            if (pending_diffs.size() == 0)
                report_mismatch("result with nothing pending", got.days_apart, 0);
            else
            begin
                want = pending_diffs.pop_front();
                if (got.days_apart !== want.days_apart)
                    report_mismatch("days_apart", got.days_apart, want.days_apart);
                if (got.a_before_b !== want.a_before_b)
                    report_mismatch("a_before_b", got.a_before_b, want.a_before_b);
                if (got.a_valid !== want.a_valid)
                    report_mismatch("a_valid", got.a_valid, want.a_valid);
                if (got.b_valid !== want.b_valid)
                    report_mismatch("b_valid", got.b_valid, want.b_valid);
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset range 1900..2100 is still in force here
        test_directed_dates();
        test_year_range(1900, 2100, 185);
        test_year_range(0, 4095, 185);
        test_year_range(4095, 0, 185);
        test_year_range(2000, 2000, 185);
        test_year_range(0, 0, 185);
        test_year_range(4095, 4095, 185);
        test_year_range($urandom_range(0, 4095), $urandom_range(0, 4095), 185);
        test_output_stall();

        settle_block();
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ sim.f @@
sv/cdd_pkg.sv
sv/cdd_date_unit.sv
sv/calendar_date_difference_top.sv
sv/cdd_checker.sv
sim/calendar_date_difference_top_tb.sv
